>>> rtl/core/b32d_pkg.sv
// Shared types, result codes and the letter table for the base32 text decoder.
// No dependencies; every module of the decoder imports this package.
`timescale 1ns / 1ps
`default_nettype none

package b32d_pkg;

  localparam int unsigned CapW     = 16;
  localparam int unsigned ExpW     = 19;
  localparam int unsigned CharCntW = 17;
  localparam int unsigned BufW     = 12;

  // ceil(2^22 / 5); exact for every operand below 2^22.
  localparam logic [19:0] RecipFive = 20'd838861;
  localparam int unsigned RecipShift = 22;

  localparam logic [CharCntW-1:0] CharCntMax = {CharCntW{1'b1}};

  localparam logic [7:0] ChEnd    = 8'h00;
  localparam logic [7:0] ChHyphen = 8'h2D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_CAPACITY = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_SYM  = 2'd0,
    KIND_SKIP = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_EXPECTED = 1'b1
  } reg_idx_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] value;
  } dec_t;

  typedef struct packed {
    logic [CapW-1:0]     capacity;
    logic                chk_en;
    logic [CharCntW-1:0] need_chars;
    logic [CapW-1:0]     need_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0]      byte_value;
    logic            is_final;
    status_t         status;
    logic [CapW-1:0] byte_total;
  } res_t;

  // Letter value by position in the alphabet (A is 1); bit 5 set marks U.
  function automatic logic [5:0] letter_val(input logic [4:0] pos);
    logic [5:0] v;
    case (pos)
      5'd1:    v = 6'd10;
      5'd2:    v = 6'd11;
      5'd3:    v = 6'd12;
      5'd4:    v = 6'd13;
      5'd5:    v = 6'd14;
      5'd6:    v = 6'd15;
      5'd7:    v = 6'd16;
      5'd8:    v = 6'd17;
      5'd9:    v = 6'd1;
      5'd10:   v = 6'd18;
      5'd11:   v = 6'd19;
      5'd12:   v = 6'd1;
      5'd13:   v = 6'd20;
      5'd14:   v = 6'd21;
      5'd15:   v = 6'd0;
      5'd16:   v = 6'd22;
      5'd17:   v = 6'd23;
      5'd18:   v = 6'd24;
      5'd19:   v = 6'd25;
      5'd20:   v = 6'd26;
      5'd22:   v = 6'd27;
      5'd23:   v = 6'd28;
      5'd24:   v = 6'd29;
      5'd25:   v = 6'd30;
      5'd26:   v = 6'd31;
      default: v = 6'd32;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/b32d_decode.sv
// Character classifier: maps one text character to a 5-bit symbol, a skip or a reject.
// Depends on b32d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b32d_decode (
  input  wire logic [7:0]    ch,
  output b32d_pkg::dec_t     dec
);
  import b32d_pkg::*;

  logic [5:0] lv;

  // Upper and lower case letters share the low five bits of their code.
  assign lv = letter_val(ch[4:0]);

  always_comb begin
    dec = '{kind: KIND_BAD, value: 5'd0};
    case (ch) inside
      ChHyphen, ChSpace, ChTab: begin
        dec.kind = KIND_SKIP;
      end
      [8'h30:8'h39]: begin
        dec.kind  = KIND_SYM;
        dec.value = {1'b0, ch[3:0]};
      end
      [8'h41:8'h5A], [8'h61:8'h7A]: begin
        if (!lv[5]) begin
          dec.kind  = KIND_SYM;
          dec.value = lv[4:0];
        end
      end
      default: begin
        dec.kind = KIND_BAD;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/b32d_cfg.sv
// Configuration registers and the length-check targets derived from them.
// Depends on b32d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b32d_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_idx,
  input  wire logic [b32d_pkg::ExpW-1:0]   cfg_wdata,
  output b32d_pkg::cfg_t                   cfg
);
  import b32d_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  logic [19:0] rounded;
  logic [39:0] prod;

  // ceil(expected / 5) as floor((expected + 4) / 5) by reciprocal multiply.
  assign rounded = {1'b0, cfg_wdata} + 20'd4;
  assign prod    = 40'(rounded) * 40'(RecipFive);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_CAPACITY: cfg_nxt.capacity = cfg_wdata[CapW-1:0];
        REG_EXPECTED: begin
          cfg_nxt.chk_en     = |cfg_wdata;
          cfg_nxt.need_chars = prod[RecipShift +: CharCntW];
          cfg_nxt.need_bytes = cfg_wdata[ExpW-1:3];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{capacity: {CapW{1'b1}}, chk_en: 1'b0,
                 need_chars: '0, need_bytes: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/core/b32d_core.sv
// Per-string decode state: bit packing, counters, sticky error and final status.
// Depends on b32d_pkg and b32d_decode.
`timescale 1ns / 1ps
`default_nettype none

module b32d_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic [7:0]            ch,
  input  wire b32d_pkg::cfg_t        cfg,
  output logic                       res_vld,
  output b32d_pkg::res_t             res
);
  import b32d_pkg::*;

  dec_t                dec;
  logic [BufW-1:0]     buf_r, buf_nxt;
  logic [2:0]          pend_r, pend_nxt;
  logic [CharCntW-1:0] ccnt_r, ccnt_nxt;
  logic [CapW-1:0]     bcnt_r, bcnt_nxt;
  status_t             err_r, err_nxt;
  logic [BufW-1:0]     packed_w;
  logic [3:0]          pend_sum;
  logic [2:0]          pend_left;
  logic [BufW-1:0]     shifted;

  b32d_decode u_decode (
    .ch  (ch),
    .dec (dec)
  );

  assign packed_w  = {buf_r[BufW-6:0], dec.value};
  assign pend_sum  = {1'b0, pend_r} + 4'd5;
  assign pend_left = 3'(pend_sum - 4'd8);
  assign shifted   = packed_w >> pend_left;

  always_comb begin
    buf_nxt  = buf_r;
    pend_nxt = pend_r;
    ccnt_nxt = ccnt_r;
    bcnt_nxt = bcnt_r;
    err_nxt  = err_r;
    res_vld  = 1'b0;
    res      = '{byte_value: 8'd0, is_final: 1'b0, status: ST_OK, byte_total: bcnt_r};
    if (step) begin
      if (ch == ChEnd) begin
        res_vld      = 1'b1;
        res.is_final = 1'b1;
        if (err_r != ST_OK) begin
          res.status = err_r;
        end else if (cfg.chk_en &&
                     (ccnt_r != cfg.need_chars || bcnt_r != cfg.need_bytes)) begin
          res.status = ST_MISMATCH;
        end
        buf_nxt  = '0;
        pend_nxt = '0;
        ccnt_nxt = '0;
        bcnt_nxt = '0;
        err_nxt  = ST_OK;
      end else if (err_r == ST_OK) begin
        case (dec.kind)
          KIND_SYM: begin
            buf_nxt = packed_w;
            if (ccnt_r != CharCntMax) begin
              ccnt_nxt = ccnt_r + 1'b1;
            end
            if (pend_sum >= 4'd8) begin
              pend_nxt = pend_left;
              // A byte completed once the limit is reached is dropped.
              if (bcnt_r >= cfg.capacity) begin
                err_nxt = ST_CAPACITY;
              end else begin
                bcnt_nxt       = bcnt_r + 1'b1;
                res_vld        = 1'b1;
                res.byte_value = shifted[7:0];
                res.byte_total = bcnt_r + 1'b1;
              end
            end else begin
              pend_nxt = pend_sum[2:0];
            end
          end
          KIND_SKIP: ;
          KIND_BAD:  err_nxt = ST_INVALID;
          default:   err_nxt = ST_INVALID;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= '0;
      pend_r <= '0;
      ccnt_r <= '0;
      bcnt_r <= '0;
      err_r  <= ST_OK;
    end else begin
      buf_r  <= buf_nxt;
      pend_r <= pend_nxt;
      ccnt_r <= ccnt_nxt;
      bcnt_r <= bcnt_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/base32_text_decoder_unit.sv
// Top level of the base32 text decoder: input register, decode core, result register.
// Depends on b32d_pkg, b32d_cfg and b32d_core.
//
//   Channel  Direction  Handshake         Beat contents
//   in_      input      valid / ready     char_code (zero ends the string)
//   out_     output     valid / ready     byte_value, is_final, status, byte_total
//   cfg_     input      write enable      idx 0 byte_capacity, idx 1 expected_bit_count
//
// A beat waits in the input register and, when it advances, its result (if any) is
// written into the result register. The sustained rate is one character per cycle
// while out_ready stays high. When the result register is held, the input register
// keeps its beat and in_ready falls until the result is taken. Synchronous reset
// clears all state but the input character and result data registers; the
// capacity resets to 65535 and the length check to off.
`timescale 1ns / 1ps
`default_nettype none

module base32_text_decoder_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_char_code,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        out_byte_value,
  output logic                              out_is_final,
  output logic [1:0]                        out_status,
  output logic [b32d_pkg::CapW-1:0]         out_byte_total,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_idx,
  input  wire logic [b32d_pkg::ExpW-1:0]    cfg_wdata
);
  import b32d_pkg::*;

  cfg_t       cfg;
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_ch_r;
  logic       advance;
  logic       res_vld;
  res_t       res;
  logic       out_vld_r, out_vld_nxt;
  res_t       out_r;

  b32d_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  b32d_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .ch      (in_ch_r),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  // The held beat moves on only when the result register can take its result.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ready) begin
      in_vld_nxt = in_valid;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = res_vld;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_ch_r <= in_char_code;
    end
    if (advance && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_byte_value = out_r.byte_value;
  assign out_is_final   = out_r.is_final;
  assign out_status     = out_r.status;
  assign out_byte_total = out_r.byte_total;

`ifndef SYNTHESIS
  a_final_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_final |-> out_byte_value == 8'd0)
    else $error("final status beat carries a nonzero byte");

  a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_final |-> out_status == ST_OK)
    else $error("data beat carries an error status");

  a_data_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_final |-> out_byte_total != '0)
    else $error("data beat reports a zero byte total");

  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with the result register empty");
`endif

endmodule

`default_nettype wire
